// ----- hdl/tept_pkg.sv -----
// ----------------------------------------------------------------------------
// tept_pkg
// Shared types and constants for the task energy and power tracker.
// ----------------------------------------------------------------------------
package tept_pkg;

  localparam logic [1:0] STATUS_START   = 2'd0;
  localparam logic [1:0] STATUS_PRIMED  = 2'd1;
  localparam logic [1:0] STATUS_UPDATED = 2'd2;

  localparam logic [63:0] POWER_SCALE = 64'd1000;
  localparam logic [63:0] ALL_ONES    = 64'hFFFF_FFFF_FFFF_FFFF;
  // Largest quotient that can be scaled by 1000 without overflow.
  localparam logic [63:0] SCALE_LIMIT = ALL_ONES / POWER_SCALE;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_READ,
    ST_DECIDE,
    ST_DIV,
    ST_SCALE,
    ST_WRITE,
    ST_OUT
  } state_t;

  // One context-switch word and one result word.
  typedef struct packed {
    logic [3:0]  cpu_index;
    logic [11:0] outgoing_slot;
    logic [11:0] incoming_slot;
    logic [63:0] time_ns;
    logic [63:0] core_energy;
  } switch_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] task_power;
    logic [63:0] task_energy;
  } tracker_word_t;

  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [63:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quotient;
  } div_rsp_t;

endpackage

// ----- hdl/tept_if.sv -----
// ----------------------------------------------------------------------------
// tept_if
// Valid/ready channel carrying one word of type word_t.
// ----------------------------------------------------------------------------
interface tept_if #(
  parameter type word_t = logic
);
  logic  valid;
  logic  ready;
  word_t word;

  modport source (output valid, output word, input ready);
  modport sink   (input valid, input word, output ready);
endinterface

// ----- hdl/task_energy_power_tracker.sv -----
// ----------------------------------------------------------------------------
// task_energy_power_tracker
// Per-task energy and power accounting driven by context-switch events.
// ----------------------------------------------------------------------------
// Usage: each input word is one context switch (core, outgoing and incoming
// task slot, timestamp, core energy counter). Exactly one output word is
// produced per input word: a status code and, after a full accounting step,
// the outgoing task's averaged power and cumulative energy.
// The block handles one event at a time and drops ready while it works.
// An event that only records a start or primes a snapshot goes from the
// read and decide states straight to the output state. An accounting
// event also passes through the divide, scale and write states; the
// 64-step radix-2 divider that forms energy delta over time delta sets
// most of its time.
// After reset the block sweeps the per-task tables once, one slot per
// cycle, and takes no word until all TASK_SLOTS (4096 by default) are swept.
// The output word is held in a register until the receiver takes it; a
// stall on the output side simply keeps the block busy, so input ready
// stays low until that word leaves. No word is lost or repeated.
// Power uses p = dE/dt (dt of zero counts as one), scaled by 1000 with
// saturation, and averaged as old/2 + new/2.
// ----------------------------------------------------------------------------
module task_energy_power_tracker
  import tept_pkg::*;
#(
  parameter int TASK_SLOTS = 4096,
  parameter int CORES      = 16
) (
  input logic clk,
  input logic rst,
  tept_if.sink   events,
  tept_if.source results
);

  localparam int SW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int CW = (CORES > 1) ? $clog2(CORES) : 1;

  // Rounded-up reciprocals scaled by 2^32; exact for the narrow slot and
  // core numbers, so the wrap needs only a constant multiply and subtract.
  localparam logic [44:0] SLOT_RECIP =
    45'(((64'd1 << 32) + 64'(TASK_SLOTS) - 64'd1) / 64'(TASK_SLOTS));
  localparam logic [36:0] CORE_RECIP =
    37'(((64'd1 << 32) + 64'(CORES) - 64'd1) / 64'(CORES));

  // Task tables live in memories; start flags and snapshot flags are
  // cleared by the sweep after reset (start flags) or by reset (core flags).
  logic [63:0] start_time   [TASK_SLOTS];
  logic        start_valid  [TASK_SLOTS];
  logic [63:0] avg_power    [TASK_SLOTS];
  logic [63:0] energy_total [TASK_SLOTS];
  logic [63:0] core_snapshot [CORES];
  logic [CORES-1:0] snapshot_valid;

  state_t state, state_next;

  logic [SW:0]   clr_count;
  logic [CW-1:0] core;
  logic [SW-1:0] out_slot, in_slot;
  logic [63:0]   now, energy;

  logic          rd_valid;
  logic [63:0]   rd_start, rd_avg, rd_total, rd_snap;
  logic          snap_ok;
  logic [63:0]   d_energy, scaled, new_avg, new_total;
  logic [1:0]    status;

  div_req_t div_req;
  div_rsp_t div_rsp;

  tept_div u_div (.clk(clk), .rst(rst), .req(div_req), .rsp(div_rsp));

  // Slot and core numbers wrap modulo the table sizes.
  function automatic logic [SW-1:0] slot_of(input logic [11:0] s);
    logic [44:0] prod;
    logic [11:0] q;
    logic [28:0] w;
    prod = 45'(s) * SLOT_RECIP;
    q    = prod[43:32];
    w    = 29'(s) - 29'(q) * 29'(TASK_SLOTS);
    return w[SW-1:0];
  endfunction

  function automatic logic [CW-1:0] core_of(input logic [3:0] c);
    logic [36:0] prod;
    logic [3:0]  q;
    logic [15:0] w;
    prod = 37'(c) * CORE_RECIP;
    q    = prod[35:32];
    w    = 16'(c) - 16'(q) * 16'(CORES);
    return w[CW-1:0];
  endfunction

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:  if (clr_count == (SW+1)'(TASK_SLOTS - 1)) state_next = ST_IDLE;
      ST_IDLE:   if (events.valid) state_next = ST_READ;
      ST_READ:   state_next = ST_DECIDE;
      ST_DECIDE: if (rd_valid && snap_ok) state_next = ST_DIV;
                 else state_next = ST_OUT;
      ST_DIV:    if (div_rsp.done) state_next = ST_SCALE;
      ST_SCALE:  state_next = ST_WRITE;
      ST_WRITE:  state_next = ST_OUT;
      ST_OUT:    if (results.ready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    events.ready    = (state == ST_IDLE);
    results.valid   = (state == ST_OUT);
    div_req.start   = (state == ST_DECIDE) && rd_valid && snap_ok;
    div_req.dividend = energy - rd_snap;
    div_req.divisor  = ((now - rd_start) == 64'd0) ? 64'd1 : (now - rd_start);
  end

  assign snap_ok = snapshot_valid[core];

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_CLEAR;
      clr_count      <= '0;
      snapshot_valid <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr_count <= clr_count + 1'b1;
      if (state == ST_DECIDE && rd_valid && !snap_ok) snapshot_valid[core] <= 1'b1;
    end
  end

  // Capture the event and read the tables.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && events.valid) begin
      core     <= core_of(events.word.cpu_index);
      out_slot <= slot_of(events.word.outgoing_slot);
      in_slot  <= slot_of(events.word.incoming_slot);
      now      <= events.word.time_ns;
      energy   <= events.word.core_energy;
    end
    if (state == ST_READ) begin
      rd_valid <= start_valid[out_slot];
      rd_start <= start_time[out_slot];
      rd_avg   <= avg_power[out_slot];
      rd_total <= energy_total[out_slot];
      rd_snap  <= core_snapshot[core];
    end
  end

  // Table writes: sweep, start record, snapshot prime, accounting update.
  always_ff @(posedge clk) begin
    if (state == ST_CLEAR) begin
      start_valid[clr_count[SW-1:0]]  <= 1'b0;
      avg_power[clr_count[SW-1:0]]    <= '0;
      energy_total[clr_count[SW-1:0]] <= '0;
    end else if (state == ST_DECIDE && !rd_valid) begin
      start_time[in_slot]  <= now;
      start_valid[in_slot] <= 1'b1;
    end else if (state == ST_WRITE) begin
      avg_power[out_slot]    <= new_avg;
      energy_total[out_slot] <= new_total;
      start_time[in_slot]    <= now;
      start_valid[in_slot]   <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DECIDE && rd_valid && !snap_ok) core_snapshot[core] <= energy;
    else if (state == ST_WRITE) core_snapshot[core] <= energy;
  end

  // Scale with saturation, then average and accumulate. The scale by 1000
  // is formed as 1024 - 16 - 8 times the quotient.
  always_ff @(posedge clk) begin
    if (state == ST_DECIDE) begin
      d_energy <= energy - rd_snap;
      status   <= !rd_valid ? STATUS_START :
                  (!snap_ok ? STATUS_PRIMED : STATUS_UPDATED);
    end
    if (state == ST_DIV && div_rsp.done) begin
      scaled <= (div_rsp.quotient > SCALE_LIMIT) ? ALL_ONES
                : (div_rsp.quotient << 10) - (div_rsp.quotient << 4)
                  - (div_rsp.quotient << 3);
    end
    if (state == ST_SCALE) begin
      new_avg   <= (rd_avg >> 1) + (scaled >> 1);
      new_total <= rd_total + d_energy;
    end
  end

  always_comb begin
    results.word.status      = status;
    results.word.task_power  = (status == STATUS_UPDATED) ? new_avg   : 64'd0;
    results.word.task_energy = (status == STATUS_UPDATED) ? new_total : 64'd0;
  end

endmodule

// ----- hdl/tept_div.sv -----
// ----------------------------------------------------------------------------
// tept_div
// Radix-2 restoring divider, 64-bit unsigned, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tept_div
  import tept_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [63:0] rem;
  logic [63:0] quo;
  logic [63:0] dvs;
  logic [6:0]  count;
  logic        busy;
  logic        fin;
  logic [64:0] trial;

  assign trial = {rem, quo[63]} - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
    end else begin
      fin <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        rem   <= '0;
        quo   <= req.dividend;
        dvs   <= req.divisor;
        count <= 7'd0;
      end else if (busy) begin
        // Shift in the next dividend bit and subtract when it fits.
        if (!trial[64]) begin
          rem <= trial[63:0];
          quo <= {quo[62:0], 1'b1};
        end else begin
          rem <= {rem[62:0], quo[63]};
          quo <= {quo[62:0], 1'b0};
        end
        count <= count + 7'd1;
        if (count == 7'd63) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end
    end
  end

  assign rsp = '{done: fin, quotient: quo};

endmodule

// ----- test/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the task energy and power tracker. Context-switch
// words go in through a valid/ready channel. Each result word is compared
// against set values or a bit-accurate predictor. A short directed table comes
// first, then random well-formed traffic with random idling on both sides.
// ----------------------------------------------------------------------------
module tb;
  import tept_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS      = 4096;
  localparam int NUM_CORES  = 16;
  localparam int RAND_WORDS = 2000;
  localparam int QUIET_TAIL = 200;
  // The clearing sweep after reset visits each of the SLOTS slots; an
  // accounting event and a receiver stall also keep both sides quiet.
  // The limit is several times the longest quiet stretch of a correct run.
  localparam int WATCHDOG   = 4 * SLOTS + 2000;
  localparam int MAX_SHOWN  = 10;

  typedef struct {
    switch_word_t  sw;
    bit            typed;
    tracker_word_t want;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  tept_if #(.word_t(switch_word_t))  events_ch ();
  tept_if #(.word_t(tracker_word_t)) results_ch ();

  task_energy_power_tracker u_dut (
    .clk     (clk),
    .rst     (rst),
    .events  (events_ch.sink),
    .results (results_ch.source)
  );

  always #5 clk = ~clk;

  // Predictor state, a private copy of the block's tables.
  logic [63:0] run_start    [SLOTS];
  bit          run_started  [SLOTS];
  logic [63:0] power_avg    [SLOTS];
  logic [63:0] energy_sum   [SLOTS];
  logic [63:0] core_snap    [NUM_CORES];
  bit          core_primed  [NUM_CORES];

  tracker_word_t pending_results[$];
  directed_row_t directed_rows[$];

  int  mismatches = 0;
  int  idle_cycles = 0;
  bit  quiet = 1'b0;
  int  ready_gap = 0;

  // Work out the result of one switch event and advance the tables.
  function automatic tracker_word_t account_switch(switch_word_t sw);
    tracker_word_t r;
    int unsigned   core;
    int unsigned   out_s;
    int unsigned   in_s;
    logic [63:0]   d_energy;
    logic [63:0]   d_time;
    logic [63:0]   quotient;
    logic [63:0]   scaled;
    core  = sw.cpu_index % NUM_CORES;
    out_s = sw.outgoing_slot % SLOTS;
    in_s  = sw.incoming_slot % SLOTS;
    r = '0;
    r.status = STATUS_START;
    if (!run_started[out_s]) begin
      run_start[in_s]   = sw.time_ns;
      run_started[in_s] = 1'b1;
      return r;
    end
    if (!core_primed[core]) begin
      core_snap[core]   = sw.core_energy;
      core_primed[core] = 1'b1;
      r.status = STATUS_PRIMED;
      return r;
    end
    d_energy = sw.core_energy - core_snap[core];
    d_time   = sw.time_ns - run_start[out_s];
    if (d_time == 64'd0) d_time = 64'd1;
    quotient = d_energy / d_time;
    scaled   = (quotient > SCALE_LIMIT) ? ALL_ONES : quotient * POWER_SCALE;
    power_avg[out_s]  = (power_avg[out_s] >> 1) + (scaled >> 1);
    energy_sum[out_s] = energy_sum[out_s] + d_energy;
    r.status      = STATUS_UPDATED;
    r.task_power  = power_avg[out_s];
    r.task_energy = energy_sum[out_s];
    // Outgoing updates come first, so the same slot in and out still
    // ends up with the new start time.
    core_snap[core]   = sw.core_energy;
    run_start[in_s]   = sw.time_ns;
    run_started[in_s] = 1'b1;
    return r;
  endfunction

  task automatic add_row(input logic [3:0] cpu, input logic [11:0] out_s,
                         input logic [11:0] in_s, input logic [63:0] t,
                         input logic [63:0] e, input bit typed,
                         input logic [1:0] st, input logic [63:0] pw,
                         input logic [63:0] en);
    directed_row_t row;
    row.sw   = '{cpu, out_s, in_s, t, e};
    row.typed = typed;
    row.want = '{st, pw, en};
    directed_rows.push_back(row);
  endtask

  // Drive one word, after an optional gap, and wait until it is taken.
  task automatic send_switch(input switch_word_t sw, input int gap);
    if (gap > 0) begin
      events_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    events_ch.valid <= 1'b1;
    events_ch.word  <= sw;
    do @(posedge clk); while (!events_ch.ready);
  endtask

  function automatic int pick_gap();
    if (quiet || $urandom_range(0, 3) != 0) return 0;
    return $urandom_range(1, 5);
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // The receiver stalls in random bursts.
  always @(posedge clk) begin
    if (rst || quiet) begin
      results_ch.ready <= 1'b1;
      ready_gap <= 0;
    end else if (ready_gap > 0) begin
      results_ch.ready <= 1'b0;
      ready_gap <= ready_gap - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      results_ch.ready <= 1'b0;
      ready_gap <= $urandom_range(0, 4);
    end else begin
      results_ch.ready <= 1'b1;
    end
  end

  // Compare every accepted result word with the oldest expectation.
  always @(posedge clk) begin
    tracker_word_t want;
    if (!rst && results_ch.valid && results_ch.ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("Unexpected result word: %p", results_ch.word);
      end else begin
        want = pending_results.pop_front();
        if (results_ch.word !== want) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN)
            $display("Mismatch: status exp %0d got %0d, power exp %h got %h, energy exp %h got %h",
                     want.status, results_ch.word.status, want.task_power,
                     results_ch.word.task_power, want.task_energy,
                     results_ch.word.task_energy);
        end
      end
    end
  end

  // Watchdog: a long stretch with no word moving on either side ends the run.
  always @(posedge clk) begin
    if ((events_ch.valid && events_ch.ready) ||
        (results_ch.valid && results_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    logic [63:0]   core_time   [NUM_CORES];
    logic [63:0]   core_energy [NUM_CORES];
    switch_word_t  sw;
    tracker_word_t predicted;
    int            pick;
    int unsigned   c;

    events_ch.valid  = 1'b0;
    events_ch.word   = '0;
    results_ch.ready = 1'b1;
    for (int i = 0; i < SLOTS; i++) begin
      run_start[i] = '0; run_started[i] = 1'b0;
      power_avg[i] = '0; energy_sum[i] = '0;
    end
    for (int i = 0; i < NUM_CORES; i++) begin
      core_snap[i] = '0; core_primed[i] = 1'b0;
      core_time[i] = 64'd1000; core_energy[i] = 64'd0;
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed table. The first rows walk one task through recording a
    // start, priming the core, a plain accounting step and a zero time delta.
    add_row(4'd0, 12'd5, 12'd5, 64'd100, 64'd0, 1, STATUS_START, '0, '0);
    add_row(4'd0, 12'd5, 12'd7, 64'd200, 64'd1000, 1, STATUS_PRIMED, '0, '0);
    add_row(4'd0, 12'd5, 12'd5, 64'd300, 64'd3000, 1, STATUS_UPDATED, 64'd5000, 64'd2000);
    add_row(4'd0, 12'd5, 12'd5, 64'd300, 64'd3000, 1, STATUS_UPDATED, 64'd2500, 64'd2000);
    // Top slot and top core with all-ones readings: the energy delta wraps
    // and the scaled power saturates.
    add_row(4'd15, 12'd4095, 12'd4095, 64'd0, ALL_ONES, 1, STATUS_START, '0, '0);
    add_row(4'd15, 12'd4095, 12'd0, ALL_ONES, ALL_ONES, 1, STATUS_PRIMED, '0, '0);
    add_row(4'd15, 12'd4095, 12'd4095, 64'd1, ALL_ONES - 1, 1, STATUS_UPDATED,
            ALL_ONES >> 1, ALL_ONES);
    // From here on the predictor supplies the expectations: energy total
    // wraps, the time delta wraps backward, and the incoming slot 0 gets a
    // recorded start.
    add_row(4'd15, 12'd4095, 12'd0, 64'd0, 64'd5, 0, '0, '0, '0);
    add_row(4'd15, 12'd0, 12'd4095, ALL_ONES, 64'd7, 0, '0, '0, '0);
    add_row(4'd0, 12'd7, 12'd2730, 64'd5000, 64'h8000_0000_0000_0000, 0, '0, '0, '0);
    add_row(4'd10, 12'd2730, 12'd1365, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555, 0, '0, '0, '0);
    add_row(4'd5, 12'd1365, 12'd1365, 64'h5555_5555_5555_5555, 64'd9, 0, '0, '0, '0);
    add_row(4'd5, 12'd1365, 12'd4095, 64'h5555_5555_5555_6000, 64'd9000009, 0, '0, '0, '0);
    add_row(4'd0, 12'd4095, 12'd5, 64'd6000, 64'd12, 0, '0, '0, '0);

    foreach (directed_rows[i]) begin
      predicted = account_switch(directed_rows[i].sw);
      pending_results.push_back(directed_rows[i].typed ? directed_rows[i].want
                                                       : predicted);
      send_switch(directed_rows[i].sw, pick_gap());
    end

    // Random traffic. Most events use a small pool of slots so tasks get
    // started and cores primed, which drives deep into accounting; the rest
    // use any slot and full-range readings.
    for (int n = 0; n < RAND_WORDS; n++) begin
      if (n == RAND_WORDS / 2) begin
        events_ch.valid <= 1'b0;
        wait (pending_results.size() == 0);
        @(posedge clk);
      end
      if (n == RAND_WORDS - QUIET_TAIL) quiet = 1'b1;
      c = $urandom_range(0, NUM_CORES - 1);
      pick = $urandom_range(0, 9);
      sw.cpu_index = 4'(c);
      if (pick < 8) begin
        sw.outgoing_slot = 12'($urandom_range(0, 15) * 257);
        sw.incoming_slot = 12'($urandom_range(0, 15) * 257);
        core_time[c]   = core_time[c] + 64'($urandom_range(0, 100000));
        core_energy[c] = core_energy[c] + (pick == 0 ? rand64() : 64'($urandom));
        sw.time_ns     = core_time[c];
        sw.core_energy = core_energy[c];
      end else begin
        sw.outgoing_slot = 12'($urandom);
        sw.incoming_slot = 12'($urandom);
        sw.time_ns       = rand64();
        sw.core_energy   = rand64();
      end
      pending_results.push_back(account_switch(sw));
      send_switch(sw, pick_gap());
    end
    events_ch.valid <= 1'b0;

    wait (pending_results.size() == 0);
    repeat (200) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
